/* design/hnps_pkg.sv */
// hnps_pkg: shared types and codes for the held note priority stack
// request and result payload structs, action, mode and register codes,
// controller to datapath command and status structs
`default_nettype none

package hnps_pkg;

  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam logic [1:0] MODE_LATEST  = 2'd0;
  localparam logic [1:0] MODE_LOWEST  = 2'd1;
  localparam logic [1:0] MODE_HIGHEST = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_LISTEN_CHANNEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_MODE  = 1'd1;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] midi_channel;
    logic [6:0] key_number;
    logic [6:0] key_velocity;
  } in_item_t;

  typedef struct packed {
    logic       any_held;
    logic [6:0] chosen_note;
    logic [6:0] chosen_velocity;
    logic       accepted;
    logic       press_dropped;
  } out_item_t;

  typedef struct packed {
    logic [6:0] note;
    logic [6:0] velocity;
  } key_entry_t;

  typedef enum logic [1:0] {
    SCAN_NONE  = 2'd0,
    SCAN_FIND  = 2'd1,
    SCAN_SHIFT = 2'd2,
    SCAN_PICK  = 2'd3
  } scan_op_t;

  typedef struct packed {
    logic     take;
    logic     exec;
    logic     find_init;
    logic     pick_init;
    scan_op_t op;
    logic     shift_commit;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic release_go;
    logic found;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/hnps_ctrl.sv */
// hnps_ctrl: sequencing state machine for one request
// drives hnps_datapath through dp_cmd_t, reads dp_status_t; uses hnps_pkg
`default_nettype none

module hnps_ctrl
  import hnps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_FIND  = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_PICK  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = SCAN_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (st.release_go) begin
          cmd.find_init = 1'b1;
          state_nxt     = ST_FIND;
        end else begin
          cmd.pick_init = 1'b1;
          state_nxt     = ST_PICK;
        end
      end
      ST_FIND: begin
        cmd.op = SCAN_FIND;
        if (st.found) begin
          state_nxt = ST_SHIFT;
        end else if (st.scan_done) begin
          cmd.pick_init = 1'b1;
          state_nxt     = ST_PICK;
        end
      end
      ST_SHIFT: begin
        cmd.op = SCAN_SHIFT;
        if (st.scan_done) begin
          cmd.shift_commit = 1'b1;
          cmd.pick_init    = 1'b1;
          state_nxt        = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.op = SCAN_PICK;
        if (st.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/hnps_datapath.sv */
// hnps_datapath: key store memory, count, scan pipeline, config and result registers
// commanded by hnps_ctrl; uses hnps_pkg
`default_nettype none

module hnps_datapath
  import hnps_pkg::*;
#(
  parameter int STACK_DEPTH = 16
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 st
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  key_entry_t mem [STACK_DEPTH];

  in_item_t      req_r;
  logic [4:0]    listen_r;
  logic [1:0]    mode_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ra_r, ra_nxt;
  logic [AW-1:0] rtag_r;
  logic          rv_r;
  key_entry_t    rd_r;
  key_entry_t    best_r;
  logic          best_valid_r;
  logic          acc_r, acc_nxt;
  logic          drop_r, drop_nxt;
  logic          out_valid_r;
  out_item_t     out_r;

  logic          passes;
  logic          press_ok;
  logic          issue;
  logic          found;
  logic          take_best;
  logic [CW-1:0] pick_start;

  assign passes   = (listen_r == 5'd0) || (listen_r == req_r.midi_channel);
  assign press_ok = (req_r.action == ACT_PRESS) && passes && (count_r < DEPTH_C);
  assign found    = (cmd.op == SCAN_FIND) && rv_r && (rd_r.note == req_r.key_number);
  assign issue    = (cmd.op != SCAN_NONE) && (ra_r < count_r) && !found;

  assign st.release_go = (req_r.action == ACT_RELEASE) && passes;
  assign st.found      = found;
  assign st.scan_done  = !rv_r && (ra_r >= count_r);
  assign st.out_free   = !out_valid_r || !out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_r <= 5'd0;
      mode_r   <= MODE_LATEST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LISTEN_CHANNEL: listen_r <= cfg_data[4:0];
        REG_PRIORITY_MODE:  mode_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r <= in_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    acc_nxt   = acc_r;
    drop_nxt  = drop_r;
    if (cmd.exec) begin
      acc_nxt  = 1'b0;
      drop_nxt = 1'b0;
      if (req_r.action == ACT_CLEAR) begin
        count_nxt = '0;
        acc_nxt   = 1'b1;
      end else if ((req_r.action == ACT_PRESS) && passes) begin
        acc_nxt = 1'b1;
        if (press_ok) begin
          count_nxt = count_r + CW'(1);
        end else begin
          drop_nxt = 1'b1;
        end
      end else if ((req_r.action == ACT_RELEASE) && passes) begin
        acc_nxt = 1'b1;
      end
    end
    if (cmd.shift_commit) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign pick_start = ((mode_r == MODE_LATEST) && (count_nxt != '0)) ?
                      (count_nxt - CW'(1)) : '0;

  always_comb begin
    ra_nxt = ra_r;
    if (cmd.find_init) begin
      ra_nxt = '0;
    end else if (cmd.pick_init) begin
      ra_nxt = pick_start;
    end else if (found) begin
      ra_nxt = CW'(rtag_r) + CW'(1);
    end else if (issue) begin
      ra_nxt = ra_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ra_r    <= '0;
      rv_r    <= 1'b0;
      acc_r   <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ra_r    <= ra_nxt;
      rv_r    <= issue;
      acc_r   <= acc_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // key store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && press_ok) begin
      mem[count_r[AW-1:0]] <= '{note: req_r.key_number, velocity: req_r.key_velocity};
    end else if ((cmd.op == SCAN_SHIFT) && rv_r) begin
      mem[rtag_r - AW'(1)] <= rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_r   <= mem[ra_r[AW-1:0]];
      rtag_r <= ra_r[AW-1:0];
    end
  end

  // best key tracking, older entry wins ties
  assign take_best = !best_valid_r ||
                     ((mode_r == MODE_LOWEST)  && (rd_r.note < best_r.note)) ||
                     ((mode_r == MODE_HIGHEST) && (rd_r.note > best_r.note));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (cmd.pick_init) begin
      best_valid_r <= 1'b0;
    end else if ((cmd.op == SCAN_PICK) && rv_r) begin
      best_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == SCAN_PICK) && rv_r && take_best) begin
      best_r <= rd_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.any_held      <= (count_r != '0);
      out_r.accepted      <= acc_r;
      out_r.press_dropped <= drop_r;
      if (best_valid_r && (mode_r inside {MODE_LATEST, MODE_LOWEST, MODE_HIGHEST})) begin
        out_r.chosen_note     <= best_r.note;
        out_r.chosen_velocity <= best_r.velocity;
      end else begin
        out_r.chosen_note     <= 7'd0;
        out_r.chosen_velocity <= 7'd0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* design/held_note_priority_stack.sv */
// held_note_priority_stack: top level, held MIDI keys in press order with priority pick
// instantiates hnps_ctrl and hnps_datapath; uses hnps_pkg
//
// in_valid/in_stall/in_data carry one MIDI event request (press, release, clear);
// a request is taken when in_valid is high and in_stall is low. every request
// gives exactly one result on out_valid/out_stall/out_data, in order.
// cfg_valid/cfg_ready/cfg_index/cfg_data write listen_channel (index 0) and
// priority_mode (index 1); cfg_ready is always high.
// one request at a time: each result is set by the walk over the key store with
// its single read port (one entry a cycle). a press, clear or filtered event
// only walks it to pick the key; a release first walks it to find and shift out
// the key. in_stall drops in the same cycle as the result appears, so the next
// request can be taken from then on.
// a finished result waits in the output register while in_stall drops, so the
// next request can be taken; if the receiver still stalls when the next
// result is ready the block holds it until the register frees.
// reset empties the store and clears the control and config registers; store entries
// need no clearing since only entries below the held count are read.
`default_nettype none

module held_note_priority_stack
  import hnps_pkg::*;
#(
  parameter int STACK_DEPTH = 16
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  hnps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  hnps_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire

/* tb/hnps_checker.sv */
// hnps_checker: watches the request, result and register write channels of the
// held note priority stack, predicts each result and compares it field by field
// depends on hnps_pkg for the payload structs, action, mode and register codes
module hnps_checker
  import hnps_pkg::*;
#(
  parameter int STACK_DEPTH = 16
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count
);

  logic [6:0]  note_store [STACK_DEPTH];
  logic [6:0]  vel_store  [STACK_DEPTH];
  int          held_total;
  logic [4:0]  listen_q;
  logic [1:0]  mode_q;
  out_item_t   expected_results [$];
  int          mismatch_total = 0;

  function automatic out_item_t track_key_event(in_item_t ev);
    out_item_t r;
    logic      passes;
    logic      found;
    logic      have_pick;
    int        i;
    int        j;
    int        best;
    r = '0;
    found = 1'b0;
    have_pick = 1'b0;
    best = 0;
    passes = (listen_q == 5'd0) || (listen_q == ev.midi_channel);
    case (ev.action)
      ACT_CLEAR: begin
        held_total = 0;
        r.accepted = 1'b1;
      end
      ACT_PRESS: begin
        if (passes) begin
          r.accepted = 1'b1;
          if (held_total < STACK_DEPTH) begin
            note_store[held_total] = ev.key_number;
            vel_store[held_total]  = ev.key_velocity;
            held_total++;
          end else begin
            r.press_dropped = 1'b1;
          end
        end
      end
      ACT_RELEASE: begin
        if (passes) begin
          r.accepted = 1'b1;
          for (i = 0; i < held_total && !found; i++) begin
            if (note_store[i] == ev.key_number) begin
              for (j = i; j + 1 < held_total; j++) begin
                note_store[j] = note_store[j+1];
                vel_store[j]  = vel_store[j+1];
              end
              held_total--;
              found = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.any_held = (held_total != 0);
    if (held_total != 0) begin
      if (mode_q == MODE_LATEST) begin
        best = held_total - 1;
        have_pick = 1'b1;
      end else if (mode_q == MODE_LOWEST || mode_q == MODE_HIGHEST) begin
        have_pick = 1'b1;
        for (i = 1; i < held_total; i++) begin
          if ((mode_q == MODE_LOWEST && note_store[i] < note_store[best]) ||
              (mode_q == MODE_HIGHEST && note_store[i] > note_store[best]))
            best = i;
        end
      end
    end
    if (have_pick) begin
      r.chosen_note     = note_store[best];
      r.chosen_velocity = vel_store[best];
    end
    return r;
  endfunction

  task automatic compare_field(string label, int want_v, int got_v);
    if (want_v != got_v) begin
      mismatch_total++;
      $display("%0t: %s expected %0d actual %0d", $time, label, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      expected_results.delete();
      held_total = 0;
      listen_q   = '0;
      mode_q     = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_total++;
          $display("%0t: result expected none actual %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          compare_field("any_held", int'(want.any_held), int'(out_data.any_held));
          compare_field("chosen_note", int'(want.chosen_note),
                        int'(out_data.chosen_note));
          compare_field("chosen_velocity", int'(want.chosen_velocity),
                        int'(out_data.chosen_velocity));
          compare_field("accepted", int'(want.accepted), int'(out_data.accepted));
          compare_field("press_dropped", int'(want.press_dropped),
                        int'(out_data.press_dropped));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LISTEN_CHANNEL: listen_q = cfg_data;
          REG_PRIORITY_MODE:  mode_q   = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_results.push_back(track_key_event(in_data));
    end
    fail_count    <= mismatch_total;
    pending_count <= expected_results.size();
  end

endmodule

/* tb/testbench.sv */
// testbench: drives key press, release and clear requests and register writes
// into held_note_priority_stack, with random idling on both channels
// depends on hnps_pkg, held_note_priority_stack and hnps_checker
module testbench;
  import hnps_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [1:0] ACT_SPARE   = 2'd3;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending_count;
  int                    cycle_count = 0;
  bit                    idle_on = 1'b1;

  held_note_priority_stack #(.STACK_DEPTH(16)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hnps_checker #(.STACK_DEPTH(16)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_event(logic [1:0] act, logic [4:0] chan, logic [6:0] note,
                            logic [6:0] vel);
    in_item_t ev;
    ev.action       = act;
    ev.midi_channel = chan;
    ev.key_number   = note;
    ev.key_velocity = vel;
    while (idle_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off new requests until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic configure(logic [4:0] chan, logic [4:0] mode_data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_LISTEN_CHANNEL;
    cfg_data  <= chan;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_PRIORITY_MODE;
    cfg_data  <= mode_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         press_pct;
    int         span;
    int         base;
    int         pick;
    logic [4:0] listen;
    logic [1:0] mode;
    logic [1:0] act;
    logic [4:0] chan;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty release, extremes, duplicates, unused action
    send_event(ACT_RELEASE, 5'd1, 7'd60, 7'd0);
    send_event(ACT_PRESS, 5'd1, 7'd127, 7'd127);
    send_event(ACT_PRESS, 5'd16, 7'd0, 7'd0);
    send_event(ACT_PRESS, 5'd5, 7'd64, 7'd33);
    send_event(ACT_PRESS, 5'd9, 7'd64, 7'd90);
    send_event(ACT_RELEASE, 5'd1, 7'd64, 7'd0);
    send_event(ACT_SPARE, 5'd1, 7'd10, 7'd10);
    send_event(ACT_RELEASE, 5'd2, 7'd99, 7'd0);
    // ties go to the older entry
    configure(5'd0, {3'b000, MODE_LOWEST});
    send_event(ACT_PRESS, 5'd3, 7'd0, 7'd55);
    send_event(ACT_PRESS, 5'd3, 7'd64, 7'd1);
    configure(5'd0, {3'b000, MODE_HIGHEST});
    send_event(ACT_PRESS, 5'd4, 7'd127, 7'd12);
    send_event(ACT_RELEASE, 5'd4, 7'd127, 7'd0);
    // channel filter, unused mode, clear past the filter
    configure(5'd5, {3'b000, MODE_SPARE});
    send_event(ACT_PRESS, 5'd6, 7'd20, 7'd20);
    send_event(ACT_PRESS, 5'd5, 7'd21, 7'd21);
    send_event(ACT_RELEASE, 5'd6, 7'd21, 7'd0);
    send_event(ACT_CLEAR, 5'd6, 7'd0, 7'd0);
    // listen channel above 16
    configure(5'd23, {3'b111, MODE_LATEST});
    send_event(ACT_PRESS, 5'd23, 7'd31, 7'd31);
    send_event(ACT_PRESS, 5'd7, 7'd31, 7'd31);
    send_event(ACT_CLEAR, 5'd31, 7'd127, 7'd127);

    for (int phase = 0; phase < 17; phase++) begin
      case (phase)
        0:       listen = 5'd0;
        1:       listen = 5'd16;
        2:       listen = 5'd31;
        3:       listen = 5'd1;
        default: begin
          pick = $urandom_range(99);
          if (pick < 50) listen = 5'd0;
          else if (pick < 85) listen = 5'($urandom_range(1, 16));
          else listen = 5'($urandom_range(17, 31));
        end
      endcase
      if (phase < 4) mode = 2'(phase);
      else if ($urandom_range(99) < 10) mode = MODE_SPARE;
      else mode = 2'($urandom_range(0, 2));
      configure(listen, {3'($urandom_range(7)), mode});
      idle_on   = !(phase >= 6 && phase <= 8);
      press_pct = (phase % 2) ? 65 : 45;
      span      = (phase % 3 == 0) ? 127 : $urandom_range(1, 7);
      base      = $urandom_range(0, 127 - span);
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(99);
        if (pick < press_pct) act = ACT_PRESS;
        else if (pick < 93) act = ACT_RELEASE;
        else if (pick < 97) act = ACT_CLEAR;
        else act = ACT_SPARE;
        if (listen != 5'd0 && $urandom_range(99) < 85) chan = listen;
        else if ($urandom_range(99) < 90) chan = 5'($urandom_range(1, 16));
        else chan = 5'($urandom_range(0, 31));
        send_event(act, chan, 7'(base + $urandom_range(span)), 7'($urandom_range(127)));
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* held_note_priority_stack.f */
design/hnps_pkg.sv
design/hnps_ctrl.sv
design/hnps_datapath.sv
design/held_note_priority_stack.sv
tb/hnps_checker.sv
tb/testbench.sv
